/* hdl/mask_window_hit_test_core_macros.svh */
// Assertion macros shared by the mask window hit test RTL.
`ifndef MASK_WINDOW_HIT_TEST_CORE_MACROS_SVH
`define MASK_WINDOW_HIT_TEST_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MWHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mask window hit test assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MWHT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mask window hit test assertion failed");

`endif

/* hdl/mwht_pkg.sv */
// Package with shared types and constants of the mask window hit test block.
`timescale 1ns / 1ps
package mwht_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned SIZE_W = 7;
	localparam int unsigned MSIZE_W = 4;
	localparam int unsigned COORD_W = 6;
	localparam int unsigned CELLS_W = 64;
	localparam int unsigned MROW_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_WIDTH  = 3'd0,
		REG_SOURCE_HEIGHT = 3'd1,
		REG_MASK_WIDTH    = 3'd2,
		REG_MASK_HEIGHT   = 3'd3,
		REG_MASK_BITS     = 3'd4
	} mwht_reg_t;

	localparam logic [SIZE_W-1:0] RST_SOURCE_WIDTH = 7'd64;
	localparam logic [SIZE_W-1:0] RST_SOURCE_HEIGHT = 7'd64;
	localparam logic [MSIZE_W-1:0] RST_MASK_WIDTH = 4'd3;
	localparam logic [MSIZE_W-1:0] RST_MASK_HEIGHT = 4'd3;
	localparam logic [CFG_DATA_W-1:0] RST_MASK_BITS = 64'd0;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mwht_row_ctl_t;

endpackage

/* hdl/mwht_if.sv */
// Handshake interfaces for the command and result channels.
`timescale 1ns / 1ps
interface mwht_cmd_if import mwht_pkg::*; ();
	logic valid;
	logic ready;
	logic mode;
	logic [COORD_W-1:0] row_index;
	logic [CELLS_W-1:0] cell_bits;
	logic [COORD_W-1:0] query_x;
	logic [COORD_W-1:0] query_y;

	modport source (output valid, mode, row_index, cell_bits, query_x, query_y, input ready);
	modport sink (input valid, mode, row_index, cell_bits, query_x, query_y, output ready);
endinterface

interface mwht_res_if;
	logic valid;
	logic ready;
	logic pixel_out;

	modport source (output valid, pixel_out, input ready);
	modport sink (input valid, pixel_out, output ready);
endinterface

/* hdl/mask_window_hit_test_core.sv */
// Top level of the mask window hit test block: row store, column lanes and sequencer.
// A load gives no result; the next item is taken in the following cycle.
// A query reads one stored row per mask row through the single read port of the row memory;
// its result passes S_READ and S_WAIT to S_DONE, which makes it valid (S_DONE directly on
// overrun or an empty mask); the next item is taken after S_DONE unless a result still waits.
// Reset restores the configuration registers; the row memory holds no data until loaded.
`timescale 1ns / 1ps
`include "mask_window_hit_test_core_macros.svh"
module mask_window_hit_test_core import mwht_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 64,
	parameter int unsigned MAX_HEIGHT = 64,
	parameter int unsigned MASK_SIZE = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	mwht_cmd_if.sink              cmd,
	mwht_res_if.source            res
);

	localparam int unsigned AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int unsigned HW = 11;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_WAIT,
		S_DONE
	} state_t;

	state_t state_q;

	logic [SIZE_W-1:0]     src_w_q;
	logic [SIZE_W-1:0]     src_h_q;
	logic [MSIZE_W-1:0]    mask_w_q;
	logic [MSIZE_W-1:0]    mask_h_q;
	logic [CFG_DATA_W-1:0] mask_bits_q;

	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [MSIZE_W-1:0] mw_q;
	logic [MSIZE_W-1:0] mh_q;
	logic [MROW_W-1:0]  r_q;
	logic               res_q;
	logic               out_valid_q;
	logic               out_pix_q;

	logic [SIZE_W-1:0]  sw_eff;
	logic [SIZE_W-1:0]  sh_eff;
	logic [MSIZE_W-1:0] mw_eff;
	logic [MSIZE_W-1:0] mh_eff;
	logic               overrun;
	logic               accept;
	logic               ram_we;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               last_row;
	logic [MAX_WIDTH-1:0] row_data;

	mwht_row_ctl_t        ctl_s1;
	logic [MASK_SIZE-1:0] mrow_s1;
	logic [MASK_SIZE-1:0] hits;
	logic                 mrg_done;
	logic                 mrg_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= RST_SOURCE_WIDTH;
			src_h_q <= RST_SOURCE_HEIGHT;
			mask_w_q <= RST_MASK_WIDTH;
			mask_h_q <= RST_MASK_HEIGHT;
			mask_bits_q <= RST_MASK_BITS;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SOURCE_WIDTH: src_w_q <= wr_data[SIZE_W-1:0];
				REG_SOURCE_HEIGHT: src_h_q <= wr_data[SIZE_W-1:0];
				REG_MASK_WIDTH: mask_w_q <= wr_data[MSIZE_W-1:0];
				REG_MASK_HEIGHT: mask_h_q <= wr_data[MSIZE_W-1:0];
				REG_MASK_BITS: mask_bits_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign sw_eff = (src_w_q > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : src_w_q;
	assign sh_eff = (HW'(src_h_q) > HW'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : src_h_q;
	assign mw_eff = (mask_w_q > MSIZE_W'(MASK_SIZE)) ? MSIZE_W'(MASK_SIZE) : mask_w_q;
	assign mh_eff = (mask_h_q > MSIZE_W'(MASK_SIZE)) ? MSIZE_W'(MASK_SIZE) : mask_h_q;
	assign overrun = (SIZE_W'(cmd.query_x) + SIZE_W'(mw_eff) > sw_eff)
		|| (SIZE_W'(cmd.query_y) + SIZE_W'(mh_eff) > sh_eff);

	assign cmd.ready = (state_q == S_IDLE);
	assign accept = cmd.valid && cmd.ready;
	assign ram_we = accept && (cmd.mode == MODE_LOAD)
		&& (HW'(cmd.row_index) < HW'(MAX_HEIGHT));

	assign rd_en = (state_q == S_READ);
	assign rd_addr = AW'(SIZE_W'(y_q) + SIZE_W'(r_q));
	assign last_row = ({1'b0, r_q} == (mh_q - MSIZE_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			x_q <= '0;
			y_q <= '0;
			mw_q <= '0;
			mh_q <= '0;
			r_q <= '0;
			res_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_pix_q <= 1'b0;
		end else begin
			if (out_valid_q && res.ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && (cmd.mode == MODE_QUERY)) begin
						x_q <= cmd.query_x;
						y_q <= cmd.query_y;
						mw_q <= mw_eff;
						mh_q <= mh_eff;
						r_q <= '0;
						if (overrun || (mw_eff == '0) || (mh_eff == '0)) begin
							res_q <= overrun;
							state_q <= S_DONE;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					r_q <= r_q + MROW_W'(1);
					if (last_row) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (mrg_done) begin
						res_q <= mrg_hit;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || res.ready) begin
						out_valid_q <= 1'b1;
						out_pix_q <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid = out_valid_q;
	assign res.pixel_out = out_pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= rd_en;
			ctl_s1.first <= (r_q == '0);
			ctl_s1.last <= last_row;
		end
	end

	always_ff @(posedge clk) begin
		mrow_s1 <= mask_bits_q[{r_q, 3'b000} +: MASK_SIZE];
	end

	mwht_ram #(
		.WIDTH(MAX_WIDTH),
		.DEPTH(MAX_HEIGHT)
	) u_rows (
		.clk(clk),
		.we(ram_we),
		.waddr(AW'(cmd.row_index)),
		.wdata(cmd.cell_bits[MAX_WIDTH-1:0]),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(row_data)
	);

	for (genvar c = 0; c < MASK_SIZE; c++) begin : g_lane
		mwht_lane #(
			.MAX_WIDTH(MAX_WIDTH),
			.LANE(c)
		) u_lane (
			.row(row_data),
			.x(x_q),
			.mw(mw_q),
			.mbit(mrow_s1[c]),
			.hit(hits[c])
		);
	end

	mwht_merge #(
		.LANES(MASK_SIZE)
	) u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl_s1),
		.hits(hits),
		.done(mrg_done),
		.hit(mrg_hit)
	);

	`MWHT_ASSERT_NXT(a_query_leaves_idle, clk, arst_n, accept && (cmd.mode == MODE_QUERY), state_q != S_IDLE)
	`MWHT_ASSERT_IMP(a_no_write_while_read, clk, arst_n, rd_en, !ram_we)
	`MWHT_ASSERT_IMP(a_merge_done_in_wait, clk, arst_n, mrg_done, state_q == S_WAIT)

endmodule

/* hdl/mwht_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module mwht_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/mwht_lane.sv */
// One mask column lane: tests the source cell under its mask cell in the current row.
`timescale 1ns / 1ps
module mwht_lane import mwht_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 64,
	parameter int unsigned LANE = 0
) (
	input  logic [MAX_WIDTH-1:0] row,
	input  logic [COORD_W-1:0]   x,
	input  logic [MSIZE_W-1:0]   mw,
	input  logic                 mbit,
	output logic                 hit
);

	localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [SIZE_W-1:0] col;
	logic              sbit;
	logic              en;

	assign col = SIZE_W'(x) + SIZE_W'(LANE);
	assign en = MSIZE_W'(LANE) < mw;
	assign sbit = (col < SIZE_W'(MAX_WIDTH)) ? row[col[CW-1:0]] : 1'b0;
	assign hit = en & mbit & sbit;

endmodule

/* hdl/mwht_merge.sv */
// Merging stage: ORs the lane hits over all rows of the window into one result.
`timescale 1ns / 1ps
module mwht_merge import mwht_pkg::*; #(
	parameter int unsigned LANES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mwht_row_ctl_t    ctl,
	input  logic [LANES-1:0] hits,
	output logic             done,
	output logic             hit
);

	logic acc_q;
	logic acc_next;

	assign acc_next = (ctl.first ? 1'b0 : acc_q) | (|hits);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 1'b0;
			done <= 1'b0;
			hit <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctl.valid) begin
				acc_q <= acc_next;
				if (ctl.last) begin
					done <= 1'b1;
					hit <= acc_next;
				end
			end
		end
	end

endmodule

/* tb/tb_mask_window_hit_test_core.sv */
// Testbench that checks every query result of the mask window hit test core against a predictor.
`timescale 1ns / 1ps
module tb_mask_window_hit_test_core;
	import mwht_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	mwht_cmd_if cmd_ch();
	mwht_res_if res_ch();

	mask_window_hit_test_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	logic [CELLS_W-1:0] src_rows [64];
	logic [SIZE_W-1:0] cfg_src_w = RST_SOURCE_WIDTH;
	logic [SIZE_W-1:0] cfg_src_h = RST_SOURCE_HEIGHT;
	logic [MSIZE_W-1:0] cfg_mask_w = RST_MASK_WIDTH;
	logic [MSIZE_W-1:0] cfg_mask_h = RST_MASK_HEIGHT;
	logic [CFG_DATA_W-1:0] cfg_mask_bits = RST_MASK_BITS;

	logic expected_pixels[$];
	int error_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;

	always #5 clk = ~clk;

	function automatic int clamp_size(input int value, input int top);
		return (value > top) ? top : value;
	endfunction

	function automatic logic predict_pixel(input logic [COORD_W-1:0] qx,
			input logic [COORD_W-1:0] qy);
		int sw, sh, mw, mh;
		sw = clamp_size(int'(cfg_src_w), 64);
		sh = clamp_size(int'(cfg_src_h), 64);
		mw = clamp_size(int'(cfg_mask_w), 8);
		mh = clamp_size(int'(cfg_mask_h), 8);
		if (int'(qx) + mw > sw || int'(qy) + mh > sh) begin
			return 1'b1;
		end
		for (int r = 0; r < mh; r++) begin
			for (int c = 0; c < mw; c++) begin
				if (cfg_mask_bits[(r * 8 + c) & 63] && src_rows[int'(qy) + r][int'(qx) + c]) begin
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic logic [CELLS_W-1:0] random_cells();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return 64'd1 << $urandom_range(63);
			3: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_item(input logic m, input logic [COORD_W-1:0] ri,
			input logic [CELLS_W-1:0] cb, input logic [COORD_W-1:0] qx,
			input logic [COORD_W-1:0] qy);
		if ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.mode <= m;
		cmd_ch.row_index <= ri;
		cmd_ch.cell_bits <= cb;
		cmd_ch.query_x <= qx;
		cmd_ch.query_y <= qy;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		if (m == MODE_QUERY) begin
			expected_pixels = {expected_pixels, predict_pixel(qx, qy)};
		end else begin
			src_rows[ri] = cb;
		end
	endtask

	task automatic send_load(input int row, input logic [CELLS_W-1:0] cells);
		send_item(MODE_LOAD, COORD_W'(row), cells, COORD_W'($urandom), COORD_W'($urandom));
	endtask

	task automatic send_query(input int qx, input int qy);
		send_item(MODE_QUERY, COORD_W'($urandom), {$urandom, $urandom}, COORD_W'(qx),
			COORD_W'(qy));
	endtask

	task automatic send_fitting_query();
		int x_top, y_top;
		x_top = clamp_size(int'(cfg_src_w), 64) - clamp_size(int'(cfg_mask_w), 8);
		y_top = clamp_size(int'(cfg_src_h), 64) - clamp_size(int'(cfg_mask_h), 8);
		if (x_top < 0 || $urandom_range(4) == 0) begin
			x_top = 63;
		end
		if (y_top < 0 || $urandom_range(4) == 0) begin
			y_top = 63;
		end
		send_query($urandom_range(x_top, 0), $urandom_range(y_top, 0));
	endtask

	// Loads have no result, so the wait after the last expected result covers one still in flight.
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input mwht_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		logic [CFG_DATA_W-1:0] data;
		data = {$urandom, $urandom};
		case (idx)
			REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT: data[SIZE_W-1:0] = value[SIZE_W-1:0];
			REG_MASK_WIDTH, REG_MASK_HEIGHT: data[MSIZE_W-1:0] = value[MSIZE_W-1:0];
			default: data = value;
		endcase
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		case (idx)
			REG_SOURCE_WIDTH: cfg_src_w = data[SIZE_W-1:0];
			REG_SOURCE_HEIGHT: cfg_src_h = data[SIZE_W-1:0];
			REG_MASK_WIDTH: cfg_mask_w = data[MSIZE_W-1:0];
			REG_MASK_HEIGHT: cfg_mask_h = data[MSIZE_W-1:0];
			REG_MASK_BITS: cfg_mask_bits = data;
			default: ;
		endcase
	endtask

	task automatic set_config(input int sw, input int sh, input int mw, input int mh,
			input logic [CFG_DATA_W-1:0] mb);
		drain();
		write_reg(REG_SOURCE_WIDTH, CFG_DATA_W'(sw));
		write_reg(REG_SOURCE_HEIGHT, CFG_DATA_W'(sh));
		write_reg(REG_MASK_WIDTH, CFG_DATA_W'(mw));
		write_reg(REG_MASK_HEIGHT, CFG_DATA_W'(mh));
		write_reg(REG_MASK_BITS, mb);
		wr_en <= 1'b0;
	endtask

	task automatic test_fill_rows();
		for (int r = 0; r < 64; r++) begin
			send_load(r, random_cells());
		end
	endtask

	task automatic test_directed();
		send_load(0, '0);
		send_load(10, 64'd1 << 20);
		send_load(63, '1);
		set_config(64, 64, 3, 3, '0);
		send_query(0, 0);
		send_query(61, 61);
		send_query(62, 0);
		send_query(0, 62);
		set_config(64, 64, 8, 8, '1);
		send_query(0, 0);
		send_query(56, 56);
		send_query(57, 0);
		send_query(0, 57);
		send_query(63, 63);
		set_config(64, 64, 1, 1, 64'd1);
		send_query(20, 10);
		send_query(21, 10);
		send_query(63, 63);
		set_config(64, 64, 4, 3, 64'd1 << 19);
		send_query(17, 8);
		send_query(16, 8);
		set_config(0, 0, 1, 1, '1);
		send_query(0, 0);
		set_config(0, 0, 0, 0, '1);
		send_query(0, 0);
		send_query(1, 0);
		set_config(64, 64, 0, 0, '1);
		send_query(63, 63);
		set_config(127, 100, 15, 9, '1);
		send_query(56, 56);
		send_query(57, 56);
	endtask

	task automatic test_random_traffic();
		int send_pcts[4] = '{0, 56, 0, 19};
		int stall_pcts[4] = '{0, 0, 56, 19};
		int sizes[4];
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = send_pcts[p];
			stall_pct = stall_pcts[p];
			for (int s = 0; s < 4; s++) begin
				for (int k = 0; k < 2; k++) begin
					case ($urandom_range(9))
						0: sizes[k] = 0;
						1: sizes[k] = $urandom_range(127, 65);
						2: sizes[k] = 64;
						default: sizes[k] = $urandom_range(64, 1);
					endcase
					case ($urandom_range(9))
						0: sizes[k + 2] = 0;
						1: sizes[k + 2] = $urandom_range(15, 9);
						2: sizes[k + 2] = 8;
						default: sizes[k + 2] = $urandom_range(8, 1);
					endcase
				end
				set_config(sizes[0], sizes[1], sizes[2], sizes[3], random_cells());
				repeat (110) begin
					if ($urandom_range(99) < 30) begin
						send_load($urandom_range(63), random_cells());
					end else begin
						send_fitting_query();
					end
				end
			end
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		set_config(64, 64, 8, 8, random_cells());
		hold_cycles = 300;
		repeat (60) send_fitting_query();
		drain();
	endtask

	always @(posedge clk) begin : result_check
		logic want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_pixels.size() == 0) begin
				$error("pixel_out: expected none, actual %0b", res_ch.pixel_out);
				error_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (res_ch.pixel_out !== want) begin
					$error("pixel_out: expected %0b, actual %0b", want, res_ch.pixel_out);
					error_count++;
				end
			end
		end
		if (hold_cycles > 0) begin
			res_ch.ready <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_SOURCE_WIDTH;
		wr_data <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.mode <= MODE_LOAD;
		cmd_ch.row_index <= '0;
		cmd_ch.cell_bits <= '0;
		cmd_ch.query_x <= '0;
		cmd_ch.query_y <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_rows();
		test_directed();
		test_random_traffic();
		test_backpressure();
		drain();
		if (error_count == 0) begin
			$display("[mask_window_hit_test_core] OK");
		end else begin
			$display("[mask_window_hit_test_core] ERROR");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("[mask_window_hit_test_core] ERROR");
		$finish;
	end

endmodule
